// ===== sv/vln_pkg.sv =====
// vln_pkg: shared types, constants and float helpers for vector3_length_normalize
// depends on nothing; every module of the block imports it, vln_stream_if does not
package vln_pkg;

  localparam logic [31:0] QNAN       = 32'h7FC00000;
  localparam logic [31:0] FP_ONE     = 32'h3F800000;
  localparam logic [31:0] FP_ZERO    = 32'h00000000;
  localparam logic [30:0] TOL_RESET  = 31'h2B8CBCCC;
  localparam logic [30:0] MIN_NORMAL = 31'h00800000;
  localparam logic [7:0]  EXP_MAX    = 8'hFF;

  // biased exponent with headroom for underflow and overflow
  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
  } vec_in_t;

  typedef struct packed {
    logic [31:0] length;
    logic [31:0] unit_x;
    logic [31:0] unit_y;
    logic [31:0] unit_z;
    logic        normalized;
  } vec_out_t;

  // unpacked operand: significand with leading one at bit 23
  typedef struct packed {
    exp_t        ex;
    logic [23:0] sig;
  } unp_t;

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == EXP_MAX) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (f[30:23] == EXP_MAX) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  // quiet nan for every computed nan
  function automatic logic [31:0] canon(input logic [31:0] f);
    return is_nan(f) ? QNAN : f;
  endfunction

  // subnormals are shifted up so the significand always leads with a one
  function automatic unp_t unpack_norm(input logic [31:0] f);
    unp_t        u;
    logic [23:0] s;
    logic [4:0]  lz;
    logic        found;
    s     = {f[30:23] != 8'd0, f[22:0]};
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && s[i]) begin
        lz    = 5'(23 - i);
        found = 1'b1;
      end
    end
    if (f[30:23] != 8'd0) begin
      u.ex  = exp_t'({4'd0, f[30:23]});
      u.sig = s;
    end else begin
      u.sig = s << lz;
      u.ex  = exp_t'(1) - exp_t'({7'd0, lz});
    end
    return u;
  endfunction

  // round to nearest even and pack; sig[26] is the leading bit, sig[0] holds sticky
  function automatic logic [31:0] round_pack(input logic sgn, input exp_t ex,
                                             input logic [26:0] sig);
    logic [26:0] sh_sig;
    logic        lost;
    logic [23:0] mant;
    logic [7:0]  ef;
    logic        g;
    logic        st;
    logic        up;
    exp_t        sh;
    logic [30:0] body;
    sh_sig = sig;
    lost   = 1'b0;
    ef     = 8'd0;
    sh     = exp_t'(1) - ex;
    if (ex >= exp_t'(255)) begin
      return {sgn, EXP_MAX, 23'd0};
    end
    if (ex >= exp_t'(1)) begin
      ef = sig[26] ? ex[7:0] : 8'd0;
    end else if (sh >= exp_t'(27)) begin
      sh_sig = 27'd0;
      lost   = |sig;
    end else begin
      sh_sig = sig >> sh[4:0];
      lost   = |(sig & ((27'd1 << sh[4:0]) - 27'd1));
    end
    mant = sh_sig[26:3];
    g    = sh_sig[2];
    st   = (|sh_sig[1:0]) | lost;
    up   = g & (st | mant[0]);
    body = {ef, mant[22:0]} + 31'(up);
    return {sgn, body};
  endfunction

endpackage

// ===== sv/vln_stream_if.sv =====
// vln_stream_if: valid/ready channel carrying one item of type data_t
// depends on nothing; payload types come from vln_pkg at instantiation
interface vln_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/vln_fmul.sv =====
// vln_fmul: three-stage single-precision multiplier, round to nearest even
// depends on vln_pkg; a tag rides along with each item
module vln_fmul import vln_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [31:0]      res,
  output logic [TAG_W-1:0] tag_out
);

  logic             v1_r, v2_r, v3_r;
  logic             spec1_r, spec2_r;
  logic [31:0]      specv1_r, specv2_r;
  logic             sgn1_r, sgn2_r;
  unp_t             ua1_r, ub1_r;
  exp_t             ex2_r;
  logic [47:0]      prod2_r;
  logic [TAG_W-1:0] tag1_r, tag2_r, tag3_r;
  logic [31:0]      res3_r;

  logic        sgn_nxt;
  logic        spec_nxt;
  logic [31:0] specv_nxt;
  logic [31:0] res_nxt;

  // special operands
  always_comb begin
    sgn_nxt   = a[31] ^ b[31];
    spec_nxt  = 1'b1;
    specv_nxt = {sgn_nxt, 31'd0};
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
      specv_nxt = QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      specv_nxt = {sgn_nxt, EXP_MAX, 23'd0};
    end else if (!is_zero(a) && !is_zero(b)) begin
      spec_nxt = 1'b0;
    end
  end

  // final rounding
  always_comb begin
    if (prod2_r[47]) begin
      res_nxt = round_pack(sgn2_r, ex2_r + exp_t'(1), {prod2_r[47:22], |prod2_r[21:0]});
    end else begin
      res_nxt = round_pack(sgn2_r, ex2_r, {prod2_r[46:21], |prod2_r[20:0]});
    end
    if (spec2_r) begin
      res_nxt = specv2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r  <= spec_nxt;
      specv1_r <= specv_nxt;
      sgn1_r   <= sgn_nxt;
      ua1_r    <= unpack_norm(a);
      ub1_r    <= unpack_norm(b);
      tag1_r   <= tag_in;
      spec2_r  <= spec1_r;
      specv2_r <= specv1_r;
      sgn2_r   <= sgn1_r;
      ex2_r    <= ua1_r.ex + ub1_r.ex - exp_t'(127);
      prod2_r  <= ua1_r.sig * ub1_r.sig;
      tag2_r   <= tag1_r;
      res3_r   <= res_nxt;
      tag3_r   <= tag2_r;
    end
  end

  assign out_valid = v3_r;
  assign res       = res3_r;
  assign tag_out   = tag3_r;

endmodule

// ===== sv/vln_fadd.sv =====
// vln_fadd: two-stage adder for non-negative single-precision operands
// depends on vln_pkg; a tag rides along with each item
module vln_fadd import vln_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [31:0]      res,
  output logic [TAG_W-1:0] tag_out
);

  logic             v1_r, v2_r;
  logic             spec1_r;
  logic [31:0]      specv1_r;
  exp_t             ex1_r;
  logic [27:0]      sum1_r;
  logic [TAG_W-1:0] tag1_r, tag2_r;
  logic [31:0]      res2_r;

  logic        spec_nxt;
  logic [31:0] specv_nxt;
  logic [7:0]  ea, eb, e_big, d;
  logic [23:0] sa, sb, s_big, s_small;
  logic [26:0] small_w, al;
  logic        st;
  logic [27:0] sum_nxt;
  logic [31:0] res_nxt;

  // align the smaller operand and add
  always_comb begin
    spec_nxt  = 1'b1;
    specv_nxt = QNAN;
    if (!is_nan(a) && !is_nan(b)) begin
      if (is_inf(a) || is_inf(b)) begin
        specv_nxt = {1'b0, EXP_MAX, 23'd0};
      end else begin
        spec_nxt = 1'b0;
      end
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    sa = {a[30:23] != 8'd0, a[22:0]};
    sb = {b[30:23] != 8'd0, b[22:0]};
    if (a[30:0] >= b[30:0]) begin
      e_big   = ea;
      s_big   = sa;
      s_small = sb;
      d       = ea - eb;
    end else begin
      e_big   = eb;
      s_big   = sb;
      s_small = sa;
      d       = eb - ea;
    end
    small_w = {s_small, 3'b000};
    if (d >= 8'd27) begin
      al = 27'd0;
      st = |s_small;
    end else begin
      al = small_w >> d;
      st = |(small_w & ((27'd1 << d[4:0]) - 27'd1));
    end
    sum_nxt = {1'b0, s_big, 3'b000} + {1'b0, al[26:1], al[0] | st};
  end

  // renormalize a carry and round
  always_comb begin
    if (sum1_r[27]) begin
      res_nxt = round_pack(1'b0, ex1_r + exp_t'(1), {sum1_r[27:2], sum1_r[1] | sum1_r[0]});
    end else begin
      res_nxt = round_pack(1'b0, ex1_r, sum1_r[26:0]);
    end
    if (spec1_r) begin
      res_nxt = specv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r  <= spec_nxt;
      specv1_r <= specv_nxt;
      ex1_r    <= exp_t'({4'd0, e_big});
      sum1_r   <= sum_nxt;
      tag1_r   <= tag_in;
      res2_r   <= res_nxt;
      tag2_r   <= tag1_r;
    end
  end

  assign out_valid = v2_r;
  assign res       = res2_r;
  assign tag_out   = tag2_r;

endmodule

// ===== sv/vln_fdiv.sv =====
// vln_fdiv: pipelined single-precision divider, one quotient bit per stage
// depends on vln_pkg; a tag rides along with each item
module vln_fdiv import vln_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [31:0]      res,
  output logic [TAG_W-1:0] tag_out
);

  // 24 significand bits plus guard and round
  localparam int NSTEP = 26;

  typedef struct packed {
    logic [24:0] rem;
    logic [25:0] quo;
    logic [23:0] den;
    exp_t        ex;
    logic        sgn;
    logic        spec;
    logic [31:0] specv;
  } div_st_t;

  div_st_t          st_r  [0:NSTEP];
  logic             v_r   [0:NSTEP];
  logic [TAG_W-1:0] tag_r [0:NSTEP];
  logic             vo_r;
  logic [31:0]      res_r;
  logic [TAG_W-1:0] tago_r;

  div_st_t     pre_nxt;
  unp_t        ua, ub;
  logic [31:0] res_nxt;

  // special operands and significand setup
  always_comb begin
    ua              = unpack_norm(a);
    ub              = unpack_norm(b);
    pre_nxt.sgn     = a[31] ^ b[31];
    pre_nxt.spec    = 1'b1;
    pre_nxt.specv   = {pre_nxt.sgn, 31'd0};
    pre_nxt.quo     = 26'd0;
    pre_nxt.den     = ub.sig;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b))) begin
      pre_nxt.specv = QNAN;
    end else if (is_inf(a) || is_zero(b)) begin
      pre_nxt.specv = {pre_nxt.sgn, EXP_MAX, 23'd0};
    end else if (!is_zero(a) && !is_inf(b)) begin
      pre_nxt.spec  = 1'b0;
    end
    if (ua.sig < ub.sig) begin
      pre_nxt.rem = {ua.sig, 1'b0};
      pre_nxt.ex  = ua.ex - ub.ex + exp_t'(126);
    end else begin
      pre_nxt.rem = {1'b0, ua.sig};
      pre_nxt.ex  = ua.ex - ub.ex + exp_t'(127);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= pre_nxt;
      tag_r[0] <= tag_in;
    end
  end

  // restoring division, one bit per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic        ge;
    logic [24:0] diff;
    div_st_t     st_nxt;

    always_comb begin
      ge         = st_r[k].rem >= {1'b0, st_r[k].den};
      diff       = ge ? (st_r[k].rem - {1'b0, st_r[k].den}) : st_r[k].rem;
      st_nxt     = st_r[k];
      st_nxt.rem = {diff[23:0], 1'b0};
      st_nxt.quo = {st_r[k].quo[24:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]  <= st_nxt;
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  // round the quotient with the remainder as sticky
  always_comb begin
    res_nxt = round_pack(st_r[NSTEP].sgn, st_r[NSTEP].ex,
                         {st_r[NSTEP].quo, st_r[NSTEP].rem != 25'd0});
    if (st_r[NSTEP].spec) begin
      res_nxt = st_r[NSTEP].specv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      tago_r <= tag_r[NSTEP];
    end
  end

  assign out_valid = vo_r;
  assign res       = res_r;
  assign tag_out   = tago_r;

endmodule

// ===== sv/vln_fsqrt.sv =====
// vln_fsqrt: pipelined single-precision square root, one root bit per stage
// depends on vln_pkg; a tag rides along with each item
module vln_fsqrt import vln_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      a,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [31:0]      res,
  output logic [TAG_W-1:0] tag_out
);

  // 24 result bits plus one rounding bit
  localparam int NSTEP = 25;

  typedef struct packed {
    logic [27:0] rem;
    logic [24:0] root;
    logic [49:0] rad;
    exp_t        bexp;
    logic        spec;
    logic [31:0] specv;
  } sq_st_t;

  sq_st_t           st_r  [0:NSTEP];
  logic             v_r   [0:NSTEP];
  logic [TAG_W-1:0] tag_r [0:NSTEP];
  logic             vo_r;
  logic [31:0]      res_r;
  logic [TAG_W-1:0] tago_r;

  sq_st_t      pre_nxt;
  unp_t        ua;
  exp_t        ex;
  logic [24:0] sig;
  logic [24:0] rnd;
  exp_t        bexp_o;
  logic [22:0] frac_o;
  logic [31:0] res_nxt;

  // special operands, exponent halving
  always_comb begin
    ua            = unpack_norm(a);
    pre_nxt.spec  = 1'b1;
    pre_nxt.specv = QNAN;
    if (a[30:23] == EXP_MAX) begin
      if (a[22:0] == 23'd0 && !a[31]) begin
        pre_nxt.specv = a;
      end
    end else if (is_zero(a)) begin
      pre_nxt.specv = a;
    end else if (!a[31]) begin
      pre_nxt.spec  = 1'b0;
    end
    ex  = ua.ex - exp_t'(127);
    sig = {1'b0, ua.sig};
    if (ex[0]) begin
      sig = {ua.sig, 1'b0};
      ex  = ex - exp_t'(1);
    end
    pre_nxt.rem  = 28'd0;
    pre_nxt.root = 25'd0;
    pre_nxt.rad  = {sig, 25'd0};
    pre_nxt.bexp = (ex >>> 1) + exp_t'(127);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= pre_nxt;
      tag_r[0] <= tag_in;
    end
  end

  // integer square root of the radicand, two radicand bits per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [27:0] r2;
    logic [27:0] trial;
    logic        ge;
    sq_st_t      st_nxt;

    always_comb begin
      r2          = {st_r[k].rem[25:0], st_r[k].rad[49:48]};
      trial       = {1'b0, st_r[k].root, 2'b01};
      ge          = r2 >= trial;
      st_nxt      = st_r[k];
      st_nxt.rem  = ge ? (r2 - trial) : r2;
      st_nxt.root = {st_r[k].root[23:0], ge};
      st_nxt.rad  = {st_r[k].rad[47:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]  <= st_nxt;
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  // round on the extra root bit and pack
  always_comb begin
    rnd    = {1'b0, st_r[NSTEP].root[24:1]} + 25'(st_r[NSTEP].root[0]);
    bexp_o = st_r[NSTEP].bexp;
    frac_o = rnd[22:0];
    if (rnd[24]) begin
      bexp_o = st_r[NSTEP].bexp + exp_t'(1);
      frac_o = rnd[23:1];
    end
    res_nxt = {1'b0, bexp_o[7:0], frac_o};
    if (st_r[NSTEP].spec) begin
      res_nxt = st_r[NSTEP].specv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      tago_r <= tag_r[NSTEP];
    end
  end

  assign out_valid = vo_r;
  assign res       = res_r;
  assign tag_out   = tago_r;

endmodule

// ===== sv/vector3_length_normalize.sv =====
// vector3_length_normalize: robust length and unit vector of a float32 3d vector
// depends on vln_pkg, vln_stream_if, vln_fdiv, vln_fmul, vln_fadd and vln_fsqrt
//
// Takes one vector per clock while the pipeline is not stalled and returns
// its length and normalized components in order. The chain runs through the
// front stage, ratio dividers, squaring, two additions, square root, scaling
// multiply, unit dividers and the output register; the dividers and the
// square root resolve one bit per pipeline stage. The whole pipeline advances
// together whenever the output register is empty or taken, so a stall on the
// output holds every item in place. The zero tolerance is written through
// cfg_we and cfg_wdata and should change only while idle.
module vector3_length_normalize import vln_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  vln_stream_if.sink   in_chan,
  vln_stream_if.source out_chan
);

  typedef struct packed {
    vec_in_t     vec;
    logic        special;
    logic [31:0] spec_len;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [30:0] mx;
  } ctx_mx_t;

  typedef struct packed {
    ctx_mx_t     cm;
    logic [31:0] m2;
  } add_tag_t;

  logic        en;
  logic [30:0] tol_r;

  // front stage
  logic        fr_v_r;
  ctx_t        fr_ctx_r;
  logic [30:0] fr_mx_r, fr_na_r, fr_nb_r;
  ctx_t        fr_ctx_nxt;
  logic [30:0] mx_nxt, na_nxt, nb_nxt;
  logic [30:0] ax, ay, az;
  logic        xz, yz, zz;

  // chain signals
  logic        dv_a, dv_b, mv_a, mv_b, av_a, av_b, sv, mv_c;
  logic        dv_x, dv_y, dv_z;
  logic [31:0] q1, q2, m1, m2, s1, s2, root, prod;
  logic [31:0] qx, qy, qz;
  ctx_t        ctx_d, ctx_m, ctx_c;
  logic [30:0] mx_d, mx_m;
  add_tag_t    at_a;
  ctx_mx_t     cm_b, cm_s;
  logic [31:0] len, len_d;
  logic        pos, pos_d;
  vec_in_t     vec_d;

  // output register
  logic        out_v_r;
  vec_out_t    out_r;
  vec_out_t    out_nxt;

  function automatic logic nan31(input logic [30:0] m);
    return (m[30:23] == EXP_MAX) && (m[22:0] != 23'd0);
  endfunction

  function automatic logic mag_ge(input logic [30:0] p, input logic [30:0] q);
    return !nan31(p) && !nan31(q) && (p >= q);
  endfunction

  assign en            = !out_v_r || out_chan.ready;
  assign in_chan.ready = en;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // zero test, pick the largest magnitude, short cases
  always_comb begin
    ax = in_chan.data.comp_x[30:0];
    ay = in_chan.data.comp_y[30:0];
    az = in_chan.data.comp_z[30:0];
    xz = !nan31(ax) && !nan31(tol_r) && (ax < tol_r);
    yz = !nan31(ay) && !nan31(tol_r) && (ay < tol_r);
    zz = !nan31(az) && !nan31(tol_r) && (az < tol_r);
    if (mag_ge(ay, ax) && mag_ge(ay, az)) begin
      mx_nxt = ay;
      na_nxt = ax;
      nb_nxt = az;
    end else if (mag_ge(az, ax) && mag_ge(az, ay)) begin
      mx_nxt = az;
      na_nxt = ay;
      nb_nxt = ax;
    end else begin
      mx_nxt = ax;
      na_nxt = ay;
      nb_nxt = az;
    end
    fr_ctx_nxt.vec      = in_chan.data;
    fr_ctx_nxt.special  = 1'b1;
    fr_ctx_nxt.spec_len = FP_ZERO;
    if (xz && yz && zz) begin
      fr_ctx_nxt.spec_len = FP_ZERO;
    end else if (xz && yz) begin
      fr_ctx_nxt.spec_len = {1'b0, az};
    end else if (xz && zz) begin
      fr_ctx_nxt.spec_len = {1'b0, ay};
    end else if (yz && zz) begin
      fr_ctx_nxt.spec_len = {1'b0, ax};
    end else if (!nan31(mx_nxt) && (mx_nxt > MIN_NORMAL)) begin
      fr_ctx_nxt.special  = 1'b0;
    end else if (mx_nxt != 31'd0 && mx_nxt[30:23] != EXP_MAX) begin
      fr_ctx_nxt.spec_len = {1'b0, mx_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (en) begin
      fr_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_ctx_r <= fr_ctx_nxt;
      fr_mx_r  <= mx_nxt;
      fr_na_r  <= na_nxt;
      fr_nb_r  <= nb_nxt;
    end
  end

  // ratios of the two smaller magnitudes to the largest
  vln_fdiv #(.TAG_W($bits(ctx_t))) u_div_a (
    .clk, .rst_n, .en, .in_valid(fr_v_r), .a({1'b0, fr_na_r}), .b({1'b0, fr_mx_r}),
    .tag_in(fr_ctx_r), .out_valid(dv_a), .res(q1), .tag_out(ctx_d)
  );

  vln_fdiv #(.TAG_W(31)) u_div_b (
    .clk, .rst_n, .en, .in_valid(fr_v_r), .a({1'b0, fr_nb_r}), .b({1'b0, fr_mx_r}),
    .tag_in(fr_mx_r), .out_valid(dv_b), .res(q2), .tag_out(mx_d)
  );

  // squares of the ratios
  vln_fmul #(.TAG_W($bits(ctx_t))) u_mul_a (
    .clk, .rst_n, .en, .in_valid(dv_a), .a(q1), .b(q1),
    .tag_in(ctx_d), .out_valid(mv_a), .res(m1), .tag_out(ctx_m)
  );

  vln_fmul #(.TAG_W(31)) u_mul_b (
    .clk, .rst_n, .en, .in_valid(dv_b), .a(q2), .b(q2),
    .tag_in(mx_d), .out_valid(mv_b), .res(m2), .tag_out(mx_m)
  );

  // 1 + a*a, then + b*b
  vln_fadd #(.TAG_W($bits(add_tag_t))) u_add_a (
    .clk, .rst_n, .en, .in_valid(mv_a), .a(FP_ONE), .b(m1),
    .tag_in({ctx_m, mx_m, m2}), .out_valid(av_a), .res(s1), .tag_out(at_a)
  );

  vln_fadd #(.TAG_W($bits(ctx_mx_t))) u_add_b (
    .clk, .rst_n, .en, .in_valid(av_a), .a(s1), .b(at_a.m2),
    .tag_in(at_a.cm), .out_valid(av_b), .res(s2), .tag_out(cm_b)
  );

  vln_fsqrt #(.TAG_W($bits(ctx_mx_t))) u_sqrt (
    .clk, .rst_n, .en, .in_valid(av_b), .a(s2),
    .tag_in(cm_b), .out_valid(sv), .res(root), .tag_out(cm_s)
  );

  // scale the root by the largest magnitude
  vln_fmul #(.TAG_W($bits(ctx_t))) u_mul_c (
    .clk, .rst_n, .en, .in_valid(sv), .a({1'b0, cm_s.mx}), .b(root),
    .tag_in(cm_s.ctx), .out_valid(mv_c), .res(prod), .tag_out(ctx_c)
  );

  // length choice and positivity
  assign len = ctx_c.special ? ctx_c.spec_len : prod;
  assign pos = !len[31] && !is_zero(len) && !is_nan(len);

  // unit components
  vln_fdiv #(.TAG_W(32)) u_div_x (
    .clk, .rst_n, .en, .in_valid(mv_c), .a(ctx_c.vec.comp_x), .b(len),
    .tag_in(len), .out_valid(dv_x), .res(qx), .tag_out(len_d)
  );

  vln_fdiv #(.TAG_W($bits(vec_in_t))) u_div_y (
    .clk, .rst_n, .en, .in_valid(mv_c), .a(ctx_c.vec.comp_y), .b(len),
    .tag_in(ctx_c.vec), .out_valid(dv_y), .res(qy), .tag_out(vec_d)
  );

  vln_fdiv #(.TAG_W(1)) u_div_z (
    .clk, .rst_n, .en, .in_valid(mv_c), .a(ctx_c.vec.comp_z), .b(len),
    .tag_in(pos), .out_valid(dv_z), .res(qz), .tag_out(pos_d)
  );

  // result item
  always_comb begin
    out_nxt.length = canon(len_d);
    if (pos_d) begin
      out_nxt.unit_x     = qx;
      out_nxt.unit_y     = qy;
      out_nxt.unit_z     = qz;
      out_nxt.normalized = 1'b1;
    end else begin
      out_nxt.unit_x     = vec_d.comp_x;
      out_nxt.unit_y     = vec_d.comp_y;
      out_nxt.unit_z     = vec_d.comp_z;
      out_nxt.normalized = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  // parallel lanes stay in step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_a == dv_b) && (mv_a == mv_b) && (dv_x == dv_y) && (dv_x == dv_z))
    else $error("parallel lanes out of step");

  // a normalized item has a positive, non-nan length
  a_norm_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.normalized |->
      !out_r.length[31] && out_r.length[30:0] != 31'd0 && !is_nan(out_r.length))
    else $error("normalized item with non-positive length");

  // an item left as is has zero or nan length
  a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.normalized |-> out_r.length == FP_ZERO || out_r.length == QNAN)
    else $error("pass-through item with unexpected length");

  // a held output blocks new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while output stalled");

endmodule
